[rtl/esc_pkg.sv]
package esc_pkg;

  localparam int unsigned EPOCH_W = 32;
  localparam int unsigned DAYS_W  = 16;
  localparam int unsigned REM_W   = 18;

  localparam logic [1:0] DIV_DAY  = 2'd0;
  localparam logic [1:0] DIV_HOUR = 2'd1;
  localparam logic [1:0] DIV_MIN  = 2'd2;

  localparam logic [REM_W-1:0] SECS_PER_DAY  = REM_W'(86400);
  localparam logic [REM_W-1:0] SECS_PER_HOUR = REM_W'(3600);
  localparam logic [REM_W-1:0] SECS_PER_MIN  = REM_W'(60);

  // ceil(2^35 / 675), ceil(2^21 / 225), ceil(2^14 / 15)
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;
  localparam logic [13:0] HOUR_RECIP = 14'd9321;
  localparam logic [10:0] MIN_RECIP  = 11'd1093;

  localparam logic [7:0] FIRST_YEAR   = 8'd70;
  localparam logic [7:0] YEAR_2100    = 8'd200;
  localparam logic [3:0] MONTH_FEB    = 4'd1;
  localparam logic [3:0] MONTH_DEC    = 4'd11;
  localparam logic [8:0] DAYS_COMMON  = 9'd365;
  localparam logic [8:0] DAYS_LEAP    = 9'd366;
  localparam logic [4:0] FEB_DAYS     = 5'd28;

  typedef struct packed {
    logic       load_input;
    logic       div_step;
    logic [1:0] div_sel;
    logic       load_hour;
    logic       load_min;
    logic       load_year;
    logic       year_step;
    logic       mon_step;
    logic       publish;
  } esc_cmd_t;

  typedef struct packed {
    logic year_fit;
    logic mon_last;
    logic out_free;
  } esc_sts_t;

  // years span 1970..2106: the only century in range that is not leap is 2100
  function automatic logic is_leap(input logic [7:0] year);
    is_leap = (year[1:0] == 2'b00) && (year != YEAR_2100);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    case (mon)
      4'd0:      month_len = 5'd31;
      MONTH_FEB: month_len = leap ? FEB_DAYS + 5'd1 : FEB_DAYS;
      4'd2:      month_len = 5'd31;
      4'd3:      month_len = 5'd30;
      4'd4:      month_len = 5'd31;
      4'd5:      month_len = 5'd30;
      4'd6:      month_len = 5'd31;
      4'd7:      month_len = 5'd31;
      4'd8:      month_len = 5'd30;
      4'd9:      month_len = 5'd31;
      4'd10:     month_len = 5'd30;
      4'd11:     month_len = 5'd31;
      default:   month_len = 5'd31;
    endcase
  endfunction

endpackage

[rtl/esc_req_if.sv]
interface esc_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink (input valid, input epoch_seconds, output ready);
endinterface

[rtl/esc_res_if.sv]
interface esc_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] year_since_1900;
  logic [3:0] month_index;
  logic [4:0] day_of_month;
  logic [4:0] hour_of_day;
  logic [5:0] minute_of_hour;
  logic [5:0] second_of_minute;

  modport source (output valid, output year_since_1900, output month_index,
                  output day_of_month, output hour_of_day, output minute_of_hour,
                  output second_of_minute, input ready);
  modport sink (input valid, input year_since_1900, input month_index,
                input day_of_month, input hour_of_day, input minute_of_hour,
                input second_of_minute, output ready);
endinterface

[rtl/esc_ctrl.sv]
module esc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              ready,
  input  esc_pkg::esc_sts_t sts,
  output esc_pkg::esc_cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DDAY = 4'd1;
  localparam logic [3:0] S_LHR  = 4'd2;
  localparam logic [3:0] S_DHR  = 4'd3;
  localparam logic [3:0] S_LMIN = 4'd4;
  localparam logic [3:0] S_DMIN = 4'd5;
  localparam logic [3:0] S_LYR  = 4'd6;
  localparam logic [3:0] S_YEAR = 4'd7;
  localparam logic [3:0] S_MON  = 4'd8;
  localparam logic [3:0] S_PUB  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.div_sel = esc_pkg::DIV_DAY;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_input = 1'b1;
          state_next     = S_DDAY;
        end
      end
      S_DDAY: begin
        cmd.div_step = 1'b1;
        state_next   = S_LHR;
      end
      S_LHR: begin
        cmd.load_hour = 1'b1;
        state_next    = S_DHR;
      end
      S_DHR: begin
        cmd.div_step = 1'b1;
        cmd.div_sel  = esc_pkg::DIV_HOUR;
        state_next   = S_LMIN;
      end
      S_LMIN: begin
        cmd.load_min = 1'b1;
        state_next   = S_DMIN;
      end
      S_DMIN: begin
        cmd.div_step = 1'b1;
        cmd.div_sel  = esc_pkg::DIV_MIN;
        state_next   = S_LYR;
      end
      S_LYR: begin
        cmd.load_year = 1'b1;
        state_next    = S_YEAR;
      end
      S_YEAR: begin
        if (sts.year_fit) begin
          state_next = S_MON;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      S_MON: begin
        if (sts.mon_last) begin
          state_next = S_PUB;
        end else begin
          cmd.mon_step = 1'b1;
        end
      end
      S_PUB: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/esc_dp.sv]
module esc_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic [31:0]       epoch_seconds,
  input  esc_pkg::esc_cmd_t cmd,
  output esc_pkg::esc_sts_t sts,
  esc_res_if.source         result
);

  logic [esc_pkg::EPOCH_W-1:0] secs;
  logic [esc_pkg::REM_W-1:0]   rem;
  logic [esc_pkg::DAYS_W-1:0]  days;
  logic [7:0]                  year;
  logic [3:0]                  mon;
  logic [4:0]                  hour;
  logic [5:0]                  minute;
  logic [5:0]                  second;
  logic                        ovalid;

  logic [50:0]                 day_prod;
  logic [26:0]                 hour_prod;
  logic [20:0]                 min_prod;
  logic [esc_pkg::REM_W-1:0]   rem_day;
  logic [esc_pkg::REM_W-1:0]   rem_hour;
  logic [esc_pkg::REM_W-1:0]   rem_min;
  logic                        leap;
  logic [8:0]                  ylen;
  logic [4:0]                  mlen;

  always_comb begin
    day_prod  = 51'(secs[31:7]) * 51'(esc_pkg::DAY_RECIP);
    hour_prod = 27'(rem[16:4]) * 27'(esc_pkg::HOUR_RECIP);
    min_prod  = 21'(rem[11:2]) * 21'(esc_pkg::MIN_RECIP);
    rem_day   = secs[esc_pkg::REM_W-1:0] - esc_pkg::REM_W'(days) * esc_pkg::SECS_PER_DAY;
    rem_hour  = rem - esc_pkg::REM_W'(hour) * esc_pkg::SECS_PER_HOUR;
    rem_min   = rem - esc_pkg::REM_W'(minute) * esc_pkg::SECS_PER_MIN;
  end

  always_comb begin
    leap         = esc_pkg::is_leap(year);
    ylen         = leap ? esc_pkg::DAYS_LEAP : esc_pkg::DAYS_COMMON;
    mlen         = esc_pkg::month_len(mon, leap);
    sts.year_fit = (days < {7'd0, ylen});
    sts.mon_last = (mon == esc_pkg::MONTH_DEC) || (days < {11'd0, mlen});
    sts.out_free = !ovalid || result.ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_input) begin
      secs <= epoch_seconds;
    end else if (cmd.div_step) begin
      case (cmd.div_sel)
        esc_pkg::DIV_DAY:  days   <= day_prod[50:35];
        esc_pkg::DIV_HOUR: hour   <= hour_prod[25:21];
        esc_pkg::DIV_MIN:  minute <= min_prod[19:14];
        default: ;
      endcase
    end else if (cmd.load_hour) begin
      rem <= rem_day;
    end else if (cmd.load_min) begin
      rem <= rem_hour;
    end else if (cmd.load_year) begin
      second <= rem_min[5:0];
      year   <= esc_pkg::FIRST_YEAR;
      mon    <= '0;
    end else if (cmd.year_step) begin
      days <= days - {7'd0, ylen};
      year <= year + 8'd1;
    end else if (cmd.mon_step) begin
      days <= days - {11'd0, mlen};
      mon  <= mon + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      result.year_since_1900  <= year;
      result.month_index      <= mon;
      result.day_of_month     <= days[4:0] + 5'd1;
      result.hour_of_day      <= hour;
      result.minute_of_hour   <= minute;
      result.second_of_minute <= second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (cmd.publish) begin
      ovalid <= 1'b1;
    end else if (result.ready) begin
      ovalid <= 1'b0;
    end
  end

  assign result.valid = ovalid;

endmodule

[rtl/epoch_seconds_to_calendar.sv]
// A request is split by reciprocal division into days, hours, minutes and
// seconds; then the year loop (one step per year after 1970) and the month
// loop (one step per month) reduce the days; publish waits for a free output.
// One request is in flight at a time; the next is taken
// once the current one has moved into the output register.
// Reset: synchronous, active high; clears the controller and the result valid.
module epoch_seconds_to_calendar (
  input logic       clk,
  input logic       rst,
  esc_req_if.sink   request,
  esc_res_if.source result
);

  esc_pkg::esc_cmd_t cmd;
  esc_pkg::esc_sts_t sts;

  esc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .ready     (request.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  esc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .epoch_seconds (request.epoch_seconds),
    .cmd           (cmd),
    .sts           (sts),
    .result        (result)
  );

  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> sts.out_free)
    else $error("result published over an untaken result");

  a_publish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> result.valid)
    else $error("published result not shown");

  a_year_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.year_since_1900 >= 8'd70) && (result.year_since_1900 <= 8'd206))
    else $error("year out of range");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.month_index <= 4'd11) && (result.day_of_month != 5'd0))
    else $error("month or day out of range");

endmodule

[test/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DAY_SECONDS    = 86400;
  localparam int unsigned HOUR_SECONDS   = 3600;
  localparam int unsigned MINUTE_SECONDS = 60;
  localparam int unsigned EPOCH_YEAR     = 1970;
  localparam int unsigned BASE_YEAR      = 1900;
  localparam int unsigned COMMON_YEAR    = 365;
  localparam int unsigned LEAP_SPAN      = 366;
  localparam int unsigned FEBRUARY       = 1;
  localparam int unsigned DECEMBER       = 11;
  localparam int unsigned LAST_DAY_INDEX = 49710;
  localparam int unsigned SETTLE_CYCLES  = 250;
  localparam int unsigned HOLD_CYCLES    = 800;

  localparam int unsigned MONTH_LENGTHS [12] =
    '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [7:0] year_since_1900;
    logic [3:0] month_index;
    logic [4:0] day_of_month;
    logic [4:0] hour_of_day;
    logic [5:0] minute_of_hour;
    logic [5:0] second_of_minute;
  } calendar_t;

  logic clk;
  logic rst;

  esc_req_if req_if ();
  esc_res_if res_if ();

  epoch_seconds_to_calendar dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_if),
    .result  (res_if)
  );

  calendar_t   expected_dates[$];
  int unsigned error_count   = 0;
  bit          random_gaps   = 1'b1;
  bit          random_stalls = 1'b1;
  int unsigned receiver_hold = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic bit gregorian_leap(int unsigned full_year);
    return (full_year % 4 == 0) && ((full_year % 100 != 0) || (full_year % 400 == 0));
  endfunction

  function automatic calendar_t epoch_to_calendar(logic [31:0] secs);
    int unsigned days;
    int unsigned rem;
    int unsigned year;
    int unsigned month;
    int unsigned span;
    calendar_t   date;
    days = secs / DAY_SECONDS;
    rem  = secs % DAY_SECONDS;
    year = EPOCH_YEAR;
    span = gregorian_leap(year) ? LEAP_SPAN : COMMON_YEAR;
    while (days >= span) begin
      days -= span;
      year++;
      span = gregorian_leap(year) ? LEAP_SPAN : COMMON_YEAR;
    end
    month = 0;
    span  = MONTH_LENGTHS[0];
    while (month < DECEMBER && days >= span) begin
      days -= span;
      month++;
      span = MONTH_LENGTHS[month] + ((month == FEBRUARY && gregorian_leap(year)) ? 1 : 0);
    end
    date.year_since_1900  = 8'(year - BASE_YEAR);
    date.month_index      = 4'(month);
    date.day_of_month     = 5'(days + 1);
    date.hour_of_day      = 5'(rem / HOUR_SECONDS);
    date.minute_of_hour   = 6'((rem % HOUR_SECONDS) / MINUTE_SECONDS);
    date.second_of_minute = 6'(rem % MINUTE_SECONDS);
    return date;
  endfunction

  function automatic int unsigned idle_length();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(20, 60);
    end
    return $urandom_range(1, 4);
  endfunction

  task automatic report_field(string field, int unsigned expected, int unsigned actual);
    if (expected != actual) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, expected, actual);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    calendar_t want;
    if (!rst && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (expected_dates.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0d-%0d-%0d %0d:%0d:%0d",
                 $time, res_if.year_since_1900, res_if.month_index, res_if.day_of_month,
                 res_if.hour_of_day, res_if.minute_of_hour, res_if.second_of_minute);
        error_count++;
      end else begin
        want = expected_dates.pop_front();
        report_field("year_since_1900", want.year_since_1900, res_if.year_since_1900);
        report_field("month_index", want.month_index, res_if.month_index);
        report_field("day_of_month", want.day_of_month, res_if.day_of_month);
        report_field("hour_of_day", want.hour_of_day, res_if.hour_of_day);
        report_field("minute_of_hour", want.minute_of_hour, res_if.minute_of_hour);
        report_field("second_of_minute", want.second_of_minute, res_if.second_of_minute);
      end
    end
  end

  initial begin : receiver
    int unsigned stall;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        stall = 0;
      end else if (receiver_hold != 0) begin
        stall = receiver_hold;
        receiver_hold = 0;
      end else if (random_stalls && $urandom_range(0, 3) == 0) begin
        stall = idle_length();
      end else begin
        stall = 0;
      end
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_if.ready <= !rst;
    end
  end

  // call at a falling edge; returns at a falling edge
  task automatic send_request(input logic [31:0] secs);
    int unsigned gap;
    req_if.valid         <= 1'b1;
    req_if.epoch_seconds <= secs;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    expected_dates.push_back(epoch_to_calendar(secs));
    gap = 0;
    if (random_gaps && $urandom_range(0, 2) != 0) begin
      gap = idle_length();
    end
    @(negedge clk);
    if (gap != 0) begin
      req_if.valid         <= 1'b0;
      req_if.epoch_seconds <= $urandom;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    wait (expected_dates.size() == 0);
    @(negedge clk);
  endtask

  task automatic test_directed_dates();
    logic [31:0] dates [18] = '{
      32'd0, 32'd59, 32'd3599, 32'd86399, 32'd86400,
      32'd94694399, 32'd94694400,
      32'd951782399, 32'd951782400, 32'd951868800, 32'd978307199,
      32'd4107542399, 32'd4107542400, 32'd4133980799,
      32'h80000000, 32'h55555555, 32'hAAAAAAAA, 32'hFFFFFFFF
    };
    foreach (dates[i]) begin
      send_request(dates[i]);
    end
    wait_for_results();
  endtask

  task automatic test_uniform_seconds(input int unsigned count);
    repeat (count) begin
      send_request($urandom);
    end
    wait_for_results();
  endtask

  task automatic test_day_edges(input int unsigned count);
    longint unsigned secs;
    repeat (count) begin
      secs = longint'($urandom_range(0, LAST_DAY_INDEX)) * DAY_SECONDS;
      case ($urandom_range(0, 2))
        0: secs += DAY_SECONDS - 1;
        1: secs += $urandom_range(0, DAY_SECONDS - 1);
        default: ;
      endcase
      if (secs > 64'hFFFF_FFFF) begin
        secs -= DAY_SECONDS;
      end
      send_request(secs[31:0]);
    end
    wait_for_results();
  endtask

  task automatic test_back_to_back(input int unsigned count);
    random_gaps   = 1'b0;
    random_stalls = 1'b0;
    test_uniform_seconds(count);
    random_gaps   = 1'b1;
    random_stalls = 1'b1;
  endtask

  task automatic test_output_hold(input int unsigned count);
    random_gaps   = 1'b0;
    random_stalls = 1'b0;
    receiver_hold = HOLD_CYCLES;
    test_uniform_seconds(count);
    random_gaps   = 1'b1;
    random_stalls = 1'b1;
  endtask

  initial begin
    rst                  = 1'b1;
    req_if.valid         = 1'b0;
    req_if.epoch_seconds = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_dates();
    test_uniform_seconds(280);
    test_day_edges(280);
    test_back_to_back(60);
    test_output_hold(12);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, expected_dates.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
